@@ rtl/gpe_pkg.sv @@
// Shared constants, codes and control types for the gait phase estimator.
`default_nettype none
package gpe_pkg;

   localparam int HISTORY_DEPTH = 4;

   localparam int TIME_W      = 32;
   localparam int GAIN_W      = 16;
   localparam int PCT_W       = 11;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Product register holds gain * time (16 x 32) or elapsed * 100.
   localparam int PROD_W     = GAIN_W + TIME_W;
   // Dividend covers elapsed * 100 (32 + 7 bits).
   localparam int DIV_W      = TIME_W + 7;
   localparam int DIVISOR_W  = TIME_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_GAIN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_GAIN = CSR_INDEX_W'(1);

   // Request kinds.
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   localparam logic [GAIN_W-1:0] UPPER_GAIN_RESET = 16'd320;
   localparam logic [GAIN_W-1:0] LOWER_GAIN_RESET = 16'd192;

   localparam logic [6:0]       PCT_SCALE = 7'd100;
   localparam logic [PCT_W-1:0] PCT_MAX   = 11'd1000;
   localparam logic [PCT_W-1:0] PCT_NONE  = 11'h7FF;

   typedef struct packed {
      logic load_req;
      logic scan_start;
      logic scan_step;
      logic mul_hi;
      logic mul_lo;
      logic shift_hist;
      logic avg_mul;
      logic set_expected;
      logic pct_mul;
      logic div_pct;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic needs_update;
      logic scan_last;
      logic hist_empty;
      logic win_ok;
      logic expected_zero;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/gpe_req_if.sv @@
// Request channel: sample tick or clear command.
`default_nettype none
interface gpe_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic                          heel_contact;
   logic                          toe_contact;
   logic [gpe_pkg::TIME_W-1:0]    time_ms;

   modport source (output valid, kind, heel_contact, toe_contact, time_ms, input ready);
   modport sink   (input valid, kind, heel_contact, toe_contact, time_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/gpe_rsp_if.sv @@
// Response channel: strike flag, gait percent and step estimate.
`default_nettype none
interface gpe_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               strike;
   logic signed [gpe_pkg::PCT_W-1:0]   gait_percent;
   logic [gpe_pkg::TIME_W-1:0]         step_estimate_ms;

   modport source (output valid, strike, gait_percent, step_estimate_ms, input ready);
   modport sink   (input valid, strike, gait_percent, step_estimate_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/gpe_csr_if.sv @@
// Configuration write channel: register index and write data.
`default_nettype none
interface gpe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gpe_pkg::CSR_INDEX_W-1:0]   index;
   logic [gpe_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/gpe_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gpe_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [gpe_pkg::DIV_W-1:0]        dividend,
   input  wire logic [gpe_pkg::DIVISOR_W-1:0]    divisor,
   output logic                                  busy,
   output logic [gpe_pkg::DIV_W-1:0]             quotient
);
   localparam int DW = gpe_pkg::DIV_W;
   localparam int SW = gpe_pkg::DIVISOR_W;

   logic [DW-1:0]                  quo_ff, quo_in;
   logic [SW-1:0]                  rem_ff, rem_in;
   logic [SW-1:0]                  dsr_ff, dsr_in;
   logic [gpe_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic [SW:0]                    rem_sh;
   logic                           ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DW-1]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? SW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[SW-1:0];
         cnt_in = cnt_ff + gpe_pkg::DIV_CNT_W'(1);
         if (cnt_ff == gpe_pkg::DIV_CNT_W'(DW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

@@ rtl/gpe_ctrl.sv @@
// Sequencing state machine of the gait phase estimator.
`default_nettype none
module gpe_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire gpe_pkg::status_type   status,
   output gpe_pkg::cmd_type           cmd
);
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_CHECK  = 11'b000_0000_0010,
      ST_SCAN   = 11'b000_0000_0100,
      ST_DECIDE = 11'b000_0000_1000,
      ST_MULLO  = 11'b000_0001_0000,
      ST_WIN    = 11'b000_0010_0000,
      ST_AVG    = 11'b000_0100_0000,
      ST_PCT    = 11'b000_1000_0000,
      ST_PSTART = 11'b001_0000_0000,
      ST_PWAIT  = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.needs_update) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_PCT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.hist_empty) begin
               cmd.shift_hist = 1'b1;
               state_in       = ST_PCT;
            end else begin
               cmd.mul_hi = 1'b1;
               state_in   = ST_MULLO;
            end
         end
         ST_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_WIN;
         end
         ST_WIN: begin
            if (status.win_ok) begin
               cmd.shift_hist = 1'b1;
               cmd.avg_mul    = 1'b1;
               state_in       = ST_AVG;
            end else begin
               state_in = ST_PCT;
            end
         end
         ST_AVG: begin
            cmd.set_expected = 1'b1;
            state_in         = ST_PCT;
         end
         ST_PCT: begin
            if (status.expected_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.pct_mul = 1'b1;
               state_in    = ST_PSTART;
            end
         end
         ST_PSTART: begin
            cmd.div_pct = 1'b1;
            state_in    = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (!status.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/gpe_dp.sv @@
// Datapath: contact state, step history, window test, averaging and percent.
`default_nettype none
module gpe_dp #(
   parameter int HISTORY_DEPTH = gpe_pkg::HISTORY_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gpe_pkg::cmd_type                   cmd,
   output gpe_pkg::status_type                     status,
   input  wire logic                               req_kind,
   input  wire logic                               req_heel_contact,
   input  wire logic                               req_toe_contact,
   input  wire logic [gpe_pkg::TIME_W-1:0]         req_time_ms,
   input  wire logic                               csr_we,
   input  wire logic [gpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [gpe_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic                                    rsp_strike,
   output logic signed [gpe_pkg::PCT_W-1:0]        rsp_gait_percent,
   output logic [gpe_pkg::TIME_W-1:0]              rsp_step_estimate_ms
);
   localparam int TW    = gpe_pkg::TIME_W;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W = TW + $clog2(HISTORY_DEPTH);
   localparam int PW    = gpe_pkg::PROD_W;
   localparam int DW    = gpe_pkg::DIV_W;

   // Average as sum * ceil(2^AVG_SHIFT / depth) >> AVG_SHIFT; the rounding
   // error of the reciprocal stays below one quotient step for any sum. The
   // reciprocal is split in two 20-bit halves, one multiply per cycle.
   localparam int AVG_SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int RECIP_SPLIT = 20;
   localparam int AVG_W       = SUM_W + RECIP_SPLIT + 1;
   localparam logic [63:0] RECIP =
      ((64'd1 << AVG_SHIFT) + 64'(HISTORY_DEPTH - 1)) / 64'(HISTORY_DEPTH);
   localparam logic [RECIP_SPLIT-1:0] RECIP_LO = RECIP[RECIP_SPLIT-1:0];
   localparam logic [RECIP_SPLIT-1:0] RECIP_HI = RECIP[2*RECIP_SPLIT-1:RECIP_SPLIT];

   logic [gpe_pkg::GAIN_W-1:0] upper_gain_ff, lower_gain_ff;
   logic                       heel_was_ff, toe_was_ff;
   logic [TW-1:0]              strike_time_ff, prior_time_ff, now_ff, expected_ff;
   logic                       hit_ff;
   logic [TW-1:0]              hist_ff [HISTORY_DEPTH];
   logic [IDX_W-1:0]           idx_ff;
   logic [TW-1:0]              hi_ff, lo_ff;
   logic                       empty_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [SUM_W-1:0]           avg_lo_ff;
   logic [PW-1:0]              prod_ff;
   logic                       ok_hi_ff;
   logic                       out_valid_ff, out_strike_ff;
   logic [gpe_pkg::PCT_W-1:0]  out_pct_ff;
   logic [TW-1:0]              out_est_ff;

   logic [TW-1:0]              step_t, elapsed, scan_v;
   logic [PW-1:0]              step_t256;
   logic                       hit_now;
   logic [AVG_W-1:0]           avg_lo_prod, avg_acc;
   logic                       div_start, div_busy;
   logic [DW-1:0]              div_dividend, div_quotient;
   logic [gpe_pkg::DIVISOR_W-1:0] div_divisor;
   logic [gpe_pkg::PCT_W-1:0]  pct_val;

   assign step_t    = strike_time_ff - prior_time_ff;
   assign step_t256 = PW'({step_t, 8'd0});
   assign elapsed   = now_ff - strike_time_ff;
   assign scan_v    = hist_ff[idx_ff];
   assign hit_now   = !heel_was_ff && !toe_was_ff && (req_heel_contact || req_toe_contact);

   assign avg_lo_prod = AVG_W'(sum_ff) * AVG_W'(RECIP_LO);
   assign avg_acc     = AVG_W'(sum_ff) * AVG_W'(RECIP_HI) + AVG_W'(avg_lo_ff);

   // Percent: elapsed * 100 over the estimate, one quotient bit per cycle.
   assign div_start    = cmd.div_pct;
   assign div_dividend = prod_ff[DW-1:0];
   assign div_divisor  = expected_ff;

   gpe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      if (expected_ff == '0) begin
         pct_val = gpe_pkg::PCT_NONE;
      end else if (div_quotient > DW'(gpe_pkg::PCT_MAX)) begin
         pct_val = gpe_pkg::PCT_MAX;
      end else begin
         pct_val = div_quotient[gpe_pkg::PCT_W-1:0];
      end
   end

   always_comb begin
      status.needs_update  = hit_ff && (prior_time_ff != '0);
      status.scan_last     = idx_ff == IDX_W'(HISTORY_DEPTH - 1);
      status.hist_empty    = empty_ff;
      status.win_ok        = ok_hi_ff && (step_t256 >= prod_ff);
      status.expected_zero = expected_ff == '0;
      status.div_busy      = div_busy;
      status.out_free      = !out_valid_ff || rsp_ready;
   end

   // Control state: contact flags, strike times, history, estimate, gains.
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_gain_ff  <= gpe_pkg::UPPER_GAIN_RESET;
         lower_gain_ff  <= gpe_pkg::LOWER_GAIN_RESET;
         heel_was_ff    <= 1'b1;
         toe_was_ff     <= 1'b1;
         strike_time_ff <= '0;
         prior_time_ff  <= '0;
         expected_ff    <= '0;
         hit_ff         <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index == gpe_pkg::CSR_UPPER_GAIN) begin
               upper_gain_ff <= csr_data;
            end else if (csr_index == gpe_pkg::CSR_LOWER_GAIN) begin
               lower_gain_ff <= csr_data;
            end
         end
         if (cmd.load_req) begin
            if (req_kind == gpe_pkg::KIND_CLEAR) begin
               hit_ff <= 1'b0;
               for (int i = 0; i < HISTORY_DEPTH; i++) begin
                  hist_ff[i] <= '0;
               end
            end else begin
               hit_ff      <= hit_now;
               heel_was_ff <= req_heel_contact;
               toe_was_ff  <= req_toe_contact;
               if (hit_now) begin
                  prior_time_ff  <= strike_time_ff;
                  strike_time_ff <= req_time_ms;
               end
            end
         end
         if (cmd.shift_hist) begin
            hist_ff[0] <= step_t;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end
         if (cmd.set_expected) begin
            expected_ff <= avg_acc[AVG_SHIFT-RECIP_SPLIT +: TW];
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the scan, window test, average and output.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         now_ff <= req_time_ms;
      end
      if (cmd.scan_start) begin
         idx_ff   <= '0;
         hi_ff    <= '0;
         lo_ff    <= '1;
         empty_ff <= 1'b0;
         sum_ff   <= SUM_W'(step_t);
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (scan_v > hi_ff) begin
            hi_ff <= scan_v;
         end
         if (scan_v < lo_ff) begin
            lo_ff <= scan_v;
         end
         if (scan_v == '0) begin
            empty_ff <= 1'b1;
         end
         // Oldest entry drops out of the average.
         if (idx_ff != IDX_W'(HISTORY_DEPTH - 1)) begin
            sum_ff <= sum_ff + SUM_W'(scan_v);
         end
      end
      if (cmd.avg_mul) begin
         avg_lo_ff <= avg_lo_prod[RECIP_SPLIT +: SUM_W];
      end
      if (cmd.mul_hi) begin
         prod_ff <= PW'(upper_gain_ff) * PW'(hi_ff);
      end else if (cmd.mul_lo) begin
         ok_hi_ff <= step_t256 <= prod_ff;
         prod_ff  <= PW'(lower_gain_ff) * PW'(lo_ff);
      end else if (cmd.pct_mul) begin
         prod_ff <= PW'(elapsed) * PW'(gpe_pkg::PCT_SCALE);
      end
      if (cmd.load_out) begin
         out_strike_ff <= hit_ff;
         out_pct_ff    <= pct_val;
         out_est_ff    <= expected_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_strike           = out_strike_ff;
   assign rsp_gait_percent     = out_pct_ff;
   assign rsp_step_estimate_ms = out_est_ff;
endmodule
`default_nettype wire

@@ rtl/gait_phase_estimator.sv @@
// Top level of the gait phase estimator: controller, datapath and channel wiring.
//
// req_chan carries one request per sample tick (kind 0: heel and toe contact
// flags plus a wrapping millisecond time) or a history clear (kind 1).
// rsp_chan returns exactly one response per request: strike flag, gait percent
// (-1 while no step estimate exists, else saturated at 1000) and step estimate.
// csr_chan writes the Q8.8 window gains (index 0 upper, index 1 lower); it is
// always ready and drops writes to other indexes.
// One request is worked on at a time: req_chan.ready is high only while the
// sequencer is idle, which it enters in the cycle after the previous response
// is loaded. With no estimate the sequencer goes from the check through the
// percent state to loading the response; else the percent runs through a
// one-bit-per-cycle divider (39 steps) first. A strike with a previous strike
// adds the history scan: while the history fills the step is stored unchecked,
// else it goes through the window test and, if it passes, is stored and averaged.
// Reset (synchronous, active high) restores gains 320 and 192, clears history
// and estimate, and takes contacts as on, so the first tick never strikes.
// A waiting response sits in the output register; a new request is taken
// meanwhile, and the sequencer holds the next response until it is taken.
`default_nettype none
module gait_phase_estimator #(
   parameter int HISTORY_DEPTH = gpe_pkg::HISTORY_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   gpe_req_if.sink   req_chan,
   gpe_rsp_if.source rsp_chan,
   gpe_csr_if.sink   csr_chan
);
   gpe_pkg::cmd_type    cmd;
   gpe_pkg::status_type status;

   // Gains take any write at once.
   assign csr_chan.ready = 1'b1;

   gpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gpe_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_kind             (req_chan.kind),
      .req_heel_contact     (req_chan.heel_contact),
      .req_toe_contact      (req_chan.toe_contact),
      .req_time_ms          (req_chan.time_ms),
      .csr_we               (csr_chan.valid),
      .csr_index            (csr_chan.index),
      .csr_data             (csr_chan.data),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_strike           (rsp_chan.strike),
      .rsp_gait_percent     (rsp_chan.gait_percent),
      .rsp_step_estimate_ms (rsp_chan.step_estimate_ms)
   );
endmodule
`default_nettype wire
